// ===== hw/rtl/mpme_pkg.sv =====
// Package with constants, operation codes and control structs of the polynomial evaluator.
`default_nettype none

package mpme_pkg;

  // Problem size and field modulus.
  localparam int unsigned NUM_COEFFS = 1024;
  localparam int unsigned NUM_POINTS = 16;
  localparam int unsigned WARPS      = 32;
  localparam logic [31:0] MODULUS    = 32'd4194304001;

  // Derived widths.
  localparam int unsigned CNT_W   = (NUM_COEFFS > 1) ? $clog2(NUM_COEFFS) : 1;
  localparam int unsigned PT_W    = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
  localparam int unsigned WARPS_W = (WARPS > 1) ? $clog2(WARPS) : 1;
  localparam int unsigned LANE_W  = 5;
  localparam int unsigned CMP_W   = ((WARPS_W > LANE_W) ? WARPS_W : LANE_W) + 1;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned POINT_W = 4;

  // Barrett constant floor(2^64 / MODULUS), worked out at elaboration.
  localparam logic [64:0] MU_FULL = (65'd1 << 64) / {33'd0, MODULUS};
  localparam logic [32:0] MU      = MU_FULL[32:0];

  // The fold multiplier 0x01000193 is 2^24 plus 0x193.
  localparam int unsigned FOLD_SHIFT = 24;
  localparam logic [63:0] FOLD_LOW   = 64'h193;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] CFG_COEF_A      = 3'd0;
  localparam logic [IDX_W-1:0] CFG_COEF_B      = 3'd1;
  localparam logic [IDX_W-1:0] CFG_COEF_C      = 3'd2;
  localparam logic [IDX_W-1:0] CFG_ROOT_W      = 3'd3;
  localparam logic [IDX_W-1:0] CFG_LANE_OFFSET = 3'd4;

  // Operations of the shared multiply-reduce unit.
  typedef enum logic [3:0] {
    OP_W2,
    OP_PW,
    OP_PW2,
    OP_SW,
    OP_SW2,
    OP_XB,
    OP_XA,
    OP_HOR,
    OP_NP1,
    OP_NP2
  } mul_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic               wr_en;
    logic [CNT_W-1:0]   addr;
    logic               mul_start;
    mul_op_e            mul_op;
    logic               init_set;
    logic               init_acc;
    logic               emit;
    logic [POINT_W-1:0] point;
    logic               last;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic              mul_done;
    logic              out_free;
    logic [LANE_W-1:0] lane;
  } ctrl_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mpme_if.sv =====
// Handshake interfaces for the coefficient input and the result output.
`default_nettype none

interface mpme_coef_if;
  logic        valid;
  logic        ready;
  logic [31:0] coefficient;

  modport source (output valid, output coefficient, input ready);
  modport sink (input valid, input coefficient, output ready);
endinterface

interface mpme_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] eval_value;
  logic [3:0]  point_index;
  logic [63:0] running_fold;
  logic        last_result;

  modport source (output valid, output eval_value, output point_index, output running_fold,
                  output last_result, input ready);
  modport sink (input valid, input eval_value, input point_index, input running_fold,
                input last_result, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/modular_polynomial_multi_eval_core.sv =====
// Top level of the polynomial evaluator modulo a prime at several points.
// Loading takes one coefficient per cycle while valid is high; the item that completes a set
// starts evaluation. Each multiply-reduce runs on the one shared four-stage unit, and the
// controller issues a new operation only after the last one is done, so the Horner loop on that
// unit sets the evaluation time, which output stalls lengthen.
// Reset clears control state and sets the registers to their reset values; no clearing pass.
`default_nettype none

module modular_polynomial_multi_eval_core
  import mpme_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  mpme_coef_if.sink             coef_in,
  mpme_res_if.source            res_out
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Controller state machine.
  mpme_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (coef_in.valid),
    .in_ready_o (coef_in.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath with memory, arithmetic unit and output register.
  mpme_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .coef_i      (coef_in.coefficient),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (res_out.ready),
    .out_valid_o (res_out.valid),
    .out_value_o (res_out.eval_value),
    .out_index_o (res_out.point_index),
    .out_fold_o  (res_out.running_fold),
    .out_last_o  (res_out.last_result)
  );

  // No multiply is issued while coefficients are being taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.mul_start |-> !coef_in.ready)
    else $error("multiply issued during loading");

  // A result is only written into a free output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.emit |-> sts.out_free)
    else $error("result emitted over a pending item");

  // Two multiplies are never issued back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.mul_start |=> !cmd.mul_start)
    else $error("back-to-back multiply issue");

  // The final result of a set carries the last point index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (res_out.valid && res_out.last_result) |->
      (res_out.point_index == POINT_W'(NUM_POINTS - 1)))
    else $error("last flag on wrong point");

endmodule

`default_nettype wire

// ===== hw/rtl/mpme_modmul.sv =====
// Four-stage multiply-add unit with Barrett reduction modulo the prime.
`default_nettype none

module mpme_modmul
  import mpme_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  input  wire logic [63:0] addend_i,
  output logic             done_o,
  output logic [63:0]      raw_o,
  output logic [31:0]      res_o
);

  logic [3:0]  vld_q;
  logic [63:0] t_q, t_d;
  logic [33:0] tl_q;
  logic [32:0] q_q, q_d;
  logic [65:0] qprod;
  logic [64:0] qm;
  logic [33:0] r_q, r_d;
  logic [33:0] r1, r2;
  logic [31:0] res_q;
  logic [33:0] mod34;

  // Stage valid chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], start_i};
    end
  end

  // Product plus addend, wrapping at 64 bits.
  assign t_d = a_i * b_i + addend_i;

  // Quotient estimate from the upper bits.
  assign qprod = t_q[63:31] * MU;
  assign q_d   = qprod[65:33];

  // Remainder estimate, below three times the modulus.
  assign qm  = q_q * {1'b0, MODULUS};
  assign r_d = tl_q - qm[33:0];

  // Two correction steps.
  assign mod34 = {2'b00, MODULUS};
  assign r1    = (r_q >= mod34) ? (r_q - mod34) : r_q;
  assign r2    = (r1 >= mod34) ? (r1 - mod34) : r1;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      t_q <= t_d;
    end
    tl_q  <= t_q[33:0];
    q_q   <= q_d;
    r_q   <= r_d;
    res_q <= r2[31:0];
  end

  assign done_o = vld_q[3];
  assign raw_o  = t_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mpme_datapath.sv =====
// Datapath: configuration, coefficient memory, point powers, Horner accumulator and fold.
`default_nettype none

module mpme_datapath
  import mpme_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_W-1:0]  cfg_data_i,
  input  wire logic [31:0]       coef_i,
  input  wire ctrl_cmd_t         cmd_i,
  output ctrl_sts_t              sts_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output logic [31:0]            out_value_o,
  output logic [POINT_W-1:0]     out_index_o,
  output logic [63:0]            out_fold_o,
  output logic                   out_last_o
);

  logic [31:0] coef_a_q, coef_b_q, coef_c_q, root_w_q;
  logic [LANE_W-1:0] lane_q;
  logic [31:0] w2_q, pw_q, pw2_q, sw_q, sw2_q, x_q, acc_q;
  logic [63:0] tmp_q, fold_q, fold_d;
  logic [31:0] store_q [NUM_COEFFS];
  logic [31:0] rdata_q;
  mul_op_e     op_q;
  logic        out_valid_q;
  logic [31:0] out_value_q;
  logic [POINT_W-1:0] out_index_q;
  logic [63:0] out_fold_q;
  logic        out_last_q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_add;
  logic        mul_done;
  logic [63:0] mul_raw;
  logic [31:0] mul_res;

  // Coefficient memory: one write port for loading, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      store_q[cmd_i.addr] <= coef_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= store_q[cmd_i.addr];
  end

  // Operand selection for the multiply-reduce unit.
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_add = '0;
    unique case (cmd_i.mul_op)
      OP_W2:   begin mul_a = root_w_q; mul_b = root_w_q; end
      OP_PW:   begin mul_a = pw_q;     mul_b = root_w_q; end
      OP_PW2:  begin mul_a = pw2_q;    mul_b = w2_q;     end
      OP_SW:   begin mul_a = sw_q;     mul_b = root_w_q; end
      OP_SW2:  begin mul_a = sw2_q;    mul_b = w2_q;     end
      OP_XB:   begin mul_a = coef_b_q; mul_b = pw_q;  mul_add = {32'd0, coef_c_q}; end
      OP_XA:   begin mul_a = coef_a_q; mul_b = pw2_q; mul_add = tmp_q;             end
      OP_HOR:  begin mul_a = acc_q;    mul_b = x_q;   mul_add = {32'd0, rdata_q};  end
      OP_NP1:  begin mul_a = pw_q;     mul_b = sw_q;     end
      OP_NP2:  begin mul_a = pw2_q;    mul_b = sw2_q;    end
      default: begin mul_a = '0;       mul_b = '0;       end
    endcase
  end

  mpme_modmul u_modmul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.mul_start),
    .a_i      (mul_a),
    .b_i      (mul_b),
    .addend_i (mul_add),
    .done_o   (mul_done),
    .raw_o    (mul_raw),
    .res_o    (mul_res)
  );

  // Next fold: fold times the FNV prime, xor the new value.
  assign fold_d = ((fold_q << FOLD_SHIFT) + (fold_q * FOLD_LOW)) ^ {32'd0, acc_q};

  // Configuration, working registers and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q    <= '0;
      coef_b_q    <= '0;
      coef_c_q    <= '0;
      root_w_q    <= 32'd1;
      lane_q      <= '0;
      w2_q        <= 32'd1;
      pw_q        <= 32'd1;
      pw2_q       <= 32'd1;
      sw_q        <= 32'd1;
      sw2_q       <= 32'd1;
      acc_q       <= '0;
      fold_q      <= '0;
      x_q         <= '0;
      tmp_q       <= '0;
      op_q        <= OP_W2;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_COEF_A:      coef_a_q <= cfg_data_i[31:0];
          CFG_COEF_B:      coef_b_q <= cfg_data_i[31:0];
          CFG_COEF_C:      coef_c_q <= cfg_data_i[31:0];
          CFG_ROOT_W:      root_w_q <= cfg_data_i[31:0];
          CFG_LANE_OFFSET: lane_q   <= cfg_data_i[LANE_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.mul_start) begin
        op_q <= cmd_i.mul_op;
      end
      if (cmd_i.init_set) begin
        pw_q   <= 32'd1;
        pw2_q  <= 32'd1;
        sw_q   <= 32'd1;
        sw2_q  <= 32'd1;
        fold_q <= '0;
      end
      if (cmd_i.init_acc) begin
        acc_q <= '0;
      end
      // Write back the result of the finished operation.
      if (mul_done) begin
        unique case (op_q)
          OP_W2:   w2_q  <= mul_res;
          OP_PW:   pw_q  <= mul_res;
          OP_PW2:  pw2_q <= mul_res;
          OP_SW:   sw_q  <= mul_res;
          OP_SW2:  sw2_q <= mul_res;
          OP_XB:   tmp_q <= mul_raw;
          OP_XA:   x_q   <= mul_res;
          OP_HOR:  acc_q <= mul_res;
          OP_NP1:  pw_q  <= mul_res;
          OP_NP2:  pw2_q <= mul_res;
          default: ;
        endcase
      end
      // Output register: load on emit, clear when the item is taken.
      if (cmd_i.emit) begin
        fold_q      <= fold_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_value_q <= acc_q;
      out_index_q <= cmd_i.point;
      out_fold_q  <= fold_d;
      out_last_q  <= cmd_i.last;
    end
  end

  assign sts_o.mul_done = mul_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.lane     = lane_q;

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_index_o = out_index_q;
  assign out_fold_o  = out_fold_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mpme_ctrl.sv =====
// Controller: sequences loading, power setup, point formula, Horner steps and result emission.
`default_nettype none

module mpme_ctrl
  import mpme_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire ctrl_sts_t sts_i,
  output ctrl_cmd_t      cmd_o
);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_W2    = 4'd1;
  localparam logic [3:0] S_PW    = 4'd2;
  localparam logic [3:0] S_PW2   = 4'd3;
  localparam logic [3:0] S_SW    = 4'd4;
  localparam logic [3:0] S_SW2   = 4'd5;
  localparam logic [3:0] S_XB    = 4'd6;
  localparam logic [3:0] S_XA    = 4'd7;
  localparam logic [3:0] S_HINIT = 4'd8;
  localparam logic [3:0] S_HOR   = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;
  localparam logic [3:0] S_NP1   = 4'd11;
  localparam logic [3:0] S_NP2   = 4'd12;

  logic [3:0]         state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [WARPS_W-1:0] i_q, i_d;
  logic [PT_W-1:0]    k_q, k_d;
  logic               issued_q, issued_d;
  logic               hlast_q, hlast_d;
  logic [WARPS_W-1:0] i_nx;
  logic               in_fire;
  logic               run_mul;
  logic               mul_fin;

  assign i_nx    = i_q + 1'b1;
  // The input is ready exactly in the load state.
  assign in_fire = in_valid_i && (state_q == S_LOAD);

  // Shared issue-and-wait handshake of every multiply state.
  assign run_mul = (state_d == state_q) && 1'b0;
  assign mul_fin = issued_q && sts_i.mul_done;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    i_d        = i_q;
    k_d        = k_q;
    issued_d   = issued_q;
    hlast_d    = hlast_q;
    in_ready_o = 1'b0;

    cmd_o           = '0;
    cmd_o.mul_op    = OP_W2;
    cmd_o.addr      = cnt_q;
    cmd_o.point     = POINT_W'(k_q);
    cmd_o.last      = (k_q == PT_W'(NUM_POINTS - 1));

    // Multiply states issue once, then wait for the unit.
    if (state_q != S_LOAD && state_q != S_HINIT && state_q != S_EMIT && !issued_q) begin
      cmd_o.mul_start = 1'b1;
      issued_d        = 1'b1;
    end else if (mul_fin) begin
      issued_d = 1'b0;
    end

    unique case (state_q)
      S_LOAD: begin
        in_ready_o  = 1'b1;
        cmd_o.wr_en = in_fire;
        if (in_fire) begin
          if (cnt_q == CNT_W'(NUM_COEFFS - 1)) begin
            cnt_d          = '0;
            i_d            = '0;
            cmd_o.init_set = 1'b1;
            state_d        = S_W2;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      S_W2: begin
        cmd_o.mul_op = OP_W2;
        if (mul_fin) begin
          state_d = (CMP_W'(sts_i.lane) > CMP_W'(i_q)) ? S_PW : S_SW;
        end
      end
      S_PW: begin
        cmd_o.mul_op = OP_PW;
        if (mul_fin) state_d = S_PW2;
      end
      S_PW2: begin
        cmd_o.mul_op = OP_PW2;
        if (mul_fin) state_d = S_SW;
      end
      S_SW: begin
        cmd_o.mul_op = OP_SW;
        if (mul_fin) state_d = S_SW2;
      end
      S_SW2: begin
        cmd_o.mul_op = OP_SW2;
        if (mul_fin) begin
          if (i_q == WARPS_W'(WARPS - 1)) begin
            k_d     = '0;
            state_d = S_XB;
          end else begin
            i_d     = i_nx;
            state_d = (CMP_W'(sts_i.lane) > CMP_W'(i_nx)) ? S_PW : S_SW;
          end
        end
      end
      S_XB: begin
        cmd_o.mul_op = OP_XB;
        if (mul_fin) state_d = S_XA;
      end
      S_XA: begin
        cmd_o.mul_op = OP_XA;
        if (mul_fin) begin
          cnt_d          = CNT_W'(NUM_COEFFS - 1);
          cmd_o.init_acc = 1'b1;
          state_d        = S_HINIT;
        end
      end
      S_HINIT: begin
        // Wait state for the registered memory read of the top coefficient.
        state_d = S_HOR;
      end
      S_HOR: begin
        cmd_o.mul_op = OP_HOR;
        // The next address is issued while the unit works.
        if (cmd_o.mul_start) begin
          hlast_d = (cnt_q == '0);
          if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
        end
        if (mul_fin && hlast_q) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = cmd_o.last ? S_LOAD : S_NP1;
        end
      end
      S_NP1: begin
        cmd_o.mul_op = OP_NP1;
        if (mul_fin) state_d = S_NP2;
      end
      S_NP2: begin
        cmd_o.mul_op = OP_NP2;
        if (mul_fin) begin
          k_d     = k_q + 1'b1;
          state_d = S_XB;
        end
      end
      default: begin
        state_d  = S_LOAD;
        issued_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      cnt_q    <= '0;
      i_q      <= '0;
      k_q      <= '0;
      issued_q <= 1'b0;
      hlast_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      i_q      <= i_d;
      k_q      <= k_d;
      issued_q <= issued_d || run_mul;
      hlast_q  <= hlast_d;
    end
  end

endmodule

`default_nettype wire
